>>> hw/rtl/msw_pkg.sv
// ----------------------------------------------------------------------------
// msw_pkg
// Shared types and constants for the two-axis motor safety interlock.
// ----------------------------------------------------------------------------
package msw_pkg;

   // Timestamp width; ages wrap modulo 2**TIME_BITS
   localparam int TIME_BITS  = 40;
   localparam int LIMIT_BITS = 24;
   localparam int TEMP_BITS  = 12;
   localparam int CSR_BITS   = 24;
   localparam int CSR_IDX_BITS = 3;

   // Request operations
   typedef enum logic [1:0] {
      OP_HEARTBEAT = 2'd0,
      OP_FEEDBACK  = 2'd1,
      OP_CHECK     = 2'd2,
      OP_SEND      = 2'd3
   } op_type;

   // Register indexes
   localparam logic [CSR_IDX_BITS-1:0] CSR_PITCH_MOTOR = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_YAW_MOTOR   = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HB_LIMIT    = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FB_LIMIT    = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_TEMP_LIMIT  = 3'd4;

   // Register reset values
   localparam logic [7:0]            PITCH_MOTOR_RST = 8'd1;
   localparam logic [7:0]            YAW_MOTOR_RST   = 8'd2;
   localparam logic [LIMIT_BITS-1:0] HB_LIMIT_RST    = 24'd100000;
   localparam logic [LIMIT_BITS-1:0] FB_LIMIT_RST    = 24'd100000;
   localparam logic [TEMP_BITS-1:0]  TEMP_LIMIT_RST  = 12'd750;

   // Axis run mode that is checked
   localparam logic [1:0] ACTIVE_MODE = 2'd2;

   // Frame types still allowed while inhibited
   localparam logic [4:0] DISCOVER_TYPE = 5'd0;
   localparam logic [4:0] STOP_TYPE     = 5'd4;
   localparam logic [4:0] READ_TYPE     = 5'd17;

   // Matched axis codes
   localparam logic [1:0] MATCH_NONE  = 2'd0;
   localparam logic [1:0] MATCH_PITCH = 2'd1;
   localparam logic [1:0] MATCH_YAW   = 2'd2;

   // Feedback record update for one axis
   typedef struct packed {
      logic                        wr;
      logic [TIME_BITS-1:0]        fb_time;
      logic [1:0]                  mode;
      logic [7:0]                  faults;
      logic signed [TEMP_BITS-1:0] temp;
   } axis_upd_type;

endpackage

>>> hw/rtl/msw_axis.sv
// ----------------------------------------------------------------------------
// msw_axis
// One axis feedback record and its stale / fault / overheat evaluation.
// ----------------------------------------------------------------------------
module msw_axis (
   input  logic                                 clock,
   input  logic                                 reset,
   input  msw_pkg::axis_upd_type                upd,
   input  logic [msw_pkg::TIME_BITS-1:0]        now,
   input  logic [msw_pkg::LIMIT_BITS-1:0]       fb_limit,
   input  logic signed [msw_pkg::TEMP_BITS-1:0] temp_limit,
   output logic                                 bad
);
   import msw_pkg::*;

   logic                        seen_ff;
   logic [TIME_BITS-1:0]        time_ff;
   logic [1:0]                  mode_ff;
   logic [7:0]                  faults_ff;
   logic signed [TEMP_BITS-1:0] temp_ff;
   logic [TIME_BITS-1:0]        age;

   // record storage; only the seen flag needs reset
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
      end else if (upd.wr) begin
         seen_ff <= 1'b1;
      end
      if (upd.wr) begin
         time_ff   <= upd.fb_time;
         mode_ff   <= upd.mode;
         faults_ff <= upd.faults;
         temp_ff   <= upd.temp;
      end
   end

   // wrapping age, then the three fault conditions for an active axis
   assign age = now - time_ff;
   assign bad = seen_ff && (mode_ff == ACTIVE_MODE) &&
                ((age > TIME_BITS'(fb_limit)) || (faults_ff != 8'd0) ||
                 (temp_ff > temp_limit));

endmodule

>>> hw/rtl/motor_safety_watchdog_gate_core.sv
// ----------------------------------------------------------------------------
// motor_safety_watchdog_gate_core
// Two-axis motor safety interlock: heartbeat / feedback tracking, watchdog
// check with sticky inhibit latch, and send gating.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one request (heartbeat, feedback, check or send). It is
//   taken at a clock edge with req_valid high and req_stall low.
//   rsp_* returns exactly one response per request, in order, taken at an
//   edge with rsp_valid high and rsp_stall low.
//   csr_* writes the id / limit registers; write only while no request is in
//   flight.
//   A request is taken into the input register, then its result into the
//   result register, where its response is valid. Throughput: one request
//   per cycle while rsp_stall is low; the whole evaluation is one pass of
//   compare logic whose longest path is a TIME_BITS-wide subtract and compare.
//   Reset (synchronous) restores register defaults, clears the heartbeat
//   time, the inhibit latch and both axis records, and empties the pipe.
//   While rsp_stall is high the response holds; one more request is still
//   taken into the input register, after which req_stall rises.
//   Only reset clears the inhibit latch.
// ----------------------------------------------------------------------------
module motor_safety_watchdog_gate_core (
   input  logic                                 clock,
   input  logic                                 reset,
   // configuration
   input  logic                                 csr_write_enable,
   input  logic [msw_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [msw_pkg::CSR_BITS-1:0]         csr_write_data,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_operation,
   input  logic [msw_pkg::TIME_BITS-1:0]        req_time_us,
   input  logic [7:0]                           req_motor_id,
   input  logic [1:0]                           req_fb_mode,
   input  logic [7:0]                           req_fb_faults,
   input  logic signed [msw_pkg::TEMP_BITS-1:0] req_fb_temp,
   input  logic [4:0]                           req_comm_type,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic                                 rsp_send_allowed,
   output logic                                 rsp_inhibited,
   output logic                                 rsp_trip_onset,
   output logic                                 rsp_issue_stops,
   output logic                                 rsp_heartbeat_stale,
   output logic                                 rsp_pitch_bad,
   output logic                                 rsp_yaw_bad,
   output logic [1:0]                           rsp_axis_matched
);
   import msw_pkg::*;

   // configuration registers
   logic [7:0]                  pitch_motor_ff;
   logic [7:0]                  yaw_motor_ff;
   logic [LIMIT_BITS-1:0]       hb_limit_ff;
   logic [LIMIT_BITS-1:0]       fb_limit_ff;
   logic signed [TEMP_BITS-1:0] temp_limit_ff;

   // input register
   logic                        s1_valid_ff, s1_valid_in;
   op_type                      s1_op_ff;
   logic [TIME_BITS-1:0]        s1_time_ff;
   logic [7:0]                  s1_motor_ff;
   logic [1:0]                  s1_mode_ff;
   logic [7:0]                  s1_faults_ff;
   logic signed [TEMP_BITS-1:0] s1_temp_ff;
   logic [4:0]                  s1_type_ff;

   // block state
   logic [TIME_BITS-1:0]        heartbeat_time_ff;
   logic                        inhibit_latch_ff, inhibit_latch_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       send_ff, send_in;
   logic       first_ff, first_in;
   logic       stops_ff, stops_in;
   logic       hb_stale_ff, hb_stale_in;
   logic       p_bad_ff, p_bad_in;
   logic       y_bad_ff, y_bad_in;
   logic [1:0] matched_ff, matched_in;
   logic       inhib_out_ff;

   logic         accept;
   logic         advance;
   logic         process;
   logic         is_check;
   logic         trip;
   logic         pitch_hit;
   logic         yaw_hit;
   logic         pitch_bad;
   logic         yaw_bad;
   logic [TIME_BITS-1:0] hb_age;
   axis_upd_type pitch_upd;
   axis_upd_type yaw_upd;

   // configuration writes; out-of-range indexes are ignored
   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_motor_ff <= PITCH_MOTOR_RST;
         yaw_motor_ff   <= YAW_MOTOR_RST;
         hb_limit_ff    <= HB_LIMIT_RST;
         fb_limit_ff    <= FB_LIMIT_RST;
         temp_limit_ff  <= TEMP_LIMIT_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_PITCH_MOTOR: pitch_motor_ff <= csr_write_data[7:0];
            CSR_YAW_MOTOR:   yaw_motor_ff   <= csr_write_data[7:0];
            CSR_HB_LIMIT:    hb_limit_ff    <= csr_write_data[LIMIT_BITS-1:0];
            CSR_FB_LIMIT:    fb_limit_ff    <= csr_write_data[LIMIT_BITS-1:0];
            CSR_TEMP_LIMIT:  temp_limit_ff  <= csr_write_data[TEMP_BITS-1:0];
            default: ;
         endcase
      end
   end

   // handshake: result register frees when empty or taken
   assign advance     = !rsp_valid_ff || !rsp_stall;
   assign req_stall   = s1_valid_ff && !advance;
   assign accept      = req_valid && !req_stall;
   assign process     = s1_valid_ff && advance;
   assign s1_valid_in = accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = process ? 1'b1 : (advance ? 1'b0 : rsp_valid_ff);

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (accept) begin
         s1_op_ff     <= op_type'(req_operation);
         s1_time_ff   <= req_time_us;
         s1_motor_ff  <= req_motor_id;
         s1_mode_ff   <= req_fb_mode;
         s1_faults_ff <= req_fb_faults;
         s1_temp_ff   <= req_fb_temp;
         s1_type_ff   <= req_comm_type;
      end
   end

   // feedback routing; pitch wins when both ids match
   assign pitch_hit = process && (s1_op_ff == OP_FEEDBACK) && (s1_motor_ff == pitch_motor_ff);
   assign yaw_hit   = process && (s1_op_ff == OP_FEEDBACK) && !pitch_hit &&
                      (s1_motor_ff == yaw_motor_ff);

   always_comb begin
      pitch_upd.wr      = pitch_hit;
      pitch_upd.fb_time = s1_time_ff;
      pitch_upd.mode    = s1_mode_ff;
      pitch_upd.faults  = s1_faults_ff;
      pitch_upd.temp    = s1_temp_ff;
      yaw_upd           = pitch_upd;
      yaw_upd.wr        = yaw_hit;
   end

   msw_axis u_pitch (
      .clock      (clock),
      .reset      (reset),
      .upd        (pitch_upd),
      .now        (s1_time_ff),
      .fb_limit   (fb_limit_ff),
      .temp_limit (temp_limit_ff),
      .bad        (pitch_bad)
   );

   msw_axis u_yaw (
      .clock      (clock),
      .reset      (reset),
      .upd        (yaw_upd),
      .now        (s1_time_ff),
      .fb_limit   (fb_limit_ff),
      .temp_limit (temp_limit_ff),
      .bad        (yaw_bad)
   );

   // watchdog check and send gating
   assign hb_age   = s1_time_ff - heartbeat_time_ff;
   assign is_check = (s1_op_ff == OP_CHECK);

   always_comb begin
      hb_stale_in = is_check && (hb_age > TIME_BITS'(hb_limit_ff));
      p_bad_in    = is_check && pitch_bad;
      y_bad_in    = is_check && yaw_bad;
      trip        = hb_stale_in || p_bad_in || y_bad_in;
      first_in    = trip && !inhibit_latch_ff;
      inhibit_latch_in = inhibit_latch_ff || trip;
      stops_in    = is_check && inhibit_latch_in;
      send_in     = (s1_op_ff == OP_SEND) &&
                    (!inhibit_latch_ff ||
                     (s1_type_ff inside {DISCOVER_TYPE, STOP_TYPE, READ_TYPE}));
      if (pitch_hit) begin
         matched_in = MATCH_PITCH;
      end else if (yaw_hit) begin
         matched_in = MATCH_YAW;
      end else begin
         matched_in = MATCH_NONE;
      end
   end

   // block state updates
   always_ff @(posedge clock) begin
      if (reset) begin
         heartbeat_time_ff <= '0;
         inhibit_latch_ff  <= 1'b0;
      end else if (process) begin
         if (s1_op_ff == OP_HEARTBEAT) begin
            heartbeat_time_ff <= s1_time_ff;
         end
         inhibit_latch_ff <= inhibit_latch_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (process) begin
         send_ff     <= send_in;
         first_ff    <= first_in;
         stops_ff    <= stops_in;
         hb_stale_ff <= hb_stale_in;
         p_bad_ff    <= p_bad_in;
         y_bad_ff    <= y_bad_in;
         matched_ff  <= matched_in;
      end
   end

   // inhibited shows the latch as it stood after this request
   always_ff @(posedge clock) begin
      if (process) begin
         inhib_out_ff <= inhibit_latch_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_send_allowed    = send_ff;
   assign rsp_inhibited       = inhib_out_ff;
   assign rsp_trip_onset      = first_ff;
   assign rsp_issue_stops     = stops_ff;
   assign rsp_heartbeat_stale = hb_stale_ff;
   assign rsp_pitch_bad       = p_bad_ff;
   assign rsp_yaw_bad         = y_bad_ff;
   assign rsp_axis_matched    = matched_ff;

   // the inhibit latch is sticky until reset
   a_latch_sticky: assert property (@(posedge clock) disable iff (reset)
      !$fell(inhibit_latch_ff))
      else $error("inhibit latch cleared without reset");

   // any reported trip cause leaves the block inhibited
   a_trip_inhibits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_heartbeat_stale || rsp_pitch_bad || rsp_yaw_bad)
      |-> rsp_inhibited && rsp_issue_stops)
      else $error("trip reported without inhibit");

   // a first trip needs a cause and was not inhibited before
   a_trip_onset: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_trip_onset
      |-> (rsp_heartbeat_stale || rsp_pitch_bad || rsp_yaw_bad) && rsp_inhibited)
      else $error("first trip without cause");

   // a taken feedback match updates exactly one axis record
   a_one_axis: assert property (@(posedge clock) disable iff (reset)
      !(pitch_upd.wr && yaw_upd.wr))
      else $error("feedback routed to both axes");

endmodule

>>> bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the two-axis motor safety interlock. A short table
// of requests walks the reset values, limit edges, timestamp wrap, trips and
// send gating; three random phases follow, each with its own register
// settings and idle pattern. Every response is compared field by field with
// the table's want for typed rows, else with a built-in model of the interlock.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import msw_pkg::*;

   // one request as driven on the req_ ports
   typedef struct packed {
      op_type      op;
      logic [39:0] stamp;
      logic [7:0]  motor;
      logic [1:0]  mode;
      logic [7:0]  faults;
      logic [11:0] temp;
      logic [4:0]  ctype;
   } gate_req_type;

   // one response as seen on the rsp_ ports
   typedef struct packed {
      logic       send_allowed;
      logic       inhibited;
      logic       trip_onset;
      logic       issue_stops;
      logic       heartbeat_stale;
      logic       pitch_bad;
      logic       yaw_bad;
      logic [1:0] axis_matched;
   } gate_verdict_type;

   typedef struct packed {
      gate_req_type     rq;
      logic             typed;
      gate_verdict_type want;
   } directed_row_type;

   // responses that can be read straight off the request
   localparam gate_verdict_type V_NONE  = '0;
   localparam gate_verdict_type V_SEND  = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, MATCH_NONE};
   localparam gate_verdict_type V_PITCH = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, MATCH_PITCH};
   localparam gate_verdict_type V_YAW   = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, MATCH_YAW};
   localparam gate_verdict_type V_LATCH = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, MATCH_NONE};
   localparam gate_verdict_type V_LSEND = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, MATCH_NONE};
   localparam gate_verdict_type V_LPIT  = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, MATCH_PITCH};
   localparam gate_verdict_type V_LYAW  = '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, MATCH_YAW};
   localparam gate_verdict_type V_FIRST = '{1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, MATCH_NONE};
   localparam gate_verdict_type V_HBOLD = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, MATCH_NONE};
   localparam gate_verdict_type V_PBAD  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, MATCH_NONE};
   localparam gate_verdict_type V_BOTH  = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, MATCH_NONE};

   // directed requests, run on the reset register values
   directed_row_type script [25] = '{
      '{'{OP_SEND,     40'd0,            8'd0,   2'd0, 8'h00, 12'sd0,    5'd5},  1'b1, V_SEND},
      // heartbeat age exactly at the limit is not stale
      '{'{OP_CHECK,    40'd100000,       8'd0,   2'd0, 8'h00, 12'sd0,    5'd0},  1'b1, V_NONE},
      '{'{OP_FEEDBACK, 40'd100000,       8'd1,   2'd2, 8'h00, 12'sd750,  5'd0},  1'b1, V_PITCH},
      '{'{OP_FEEDBACK, 40'd100000,       8'd2,   2'd2, 8'h00, -12'sd400, 5'd0},  1'b1, V_YAW},
      // unmatched id stores nothing
      '{'{OP_FEEDBACK, 40'd100000,       8'd255, 2'd2, 8'hFF, 12'sd2000, 5'd31}, 1'b1, V_NONE},
      '{'{OP_HEARTBEAT, 40'd150000,      8'd0,   2'd0, 8'h00, 12'sd0,    5'd0},  1'b1, V_NONE},
      // feedback age at the limit, temperature equal to the limit
      '{'{OP_CHECK,    40'd200000,       8'd0,   2'd0, 8'h00, 12'sd0,    5'd0},  1'b0, V_NONE},
      '{'{OP_FEEDBACK, 40'd200000,       8'd1,   2'd1, 8'hFF, 12'sd2000, 5'd0},  1'b1, V_PITCH},
      '{'{OP_CHECK,    40'd200000,       8'd0,   2'd0, 8'h00, 12'sd0,    5'd0},  1'b0, V_NONE},
      '{'{OP_SEND,     40'd200000,       8'd0,   2'd0, 8'h00, 12'sd0,    5'd17}, 1'b1, V_SEND},
      '{'{OP_SEND,     40'd200000,       8'd0,   2'd0, 8'h00, 12'sd0,    5'd31}, 1'b1, V_SEND},
      '{'{OP_FEEDBACK, 40'd250000,       8'd2,   2'd3, 8'h80, 12'sd0,    5'd0},  1'b1, V_YAW},
      // stamps just below the wrap, check just after it
      '{'{OP_HEARTBEAT, 40'hFF_FFFF_FFF0, 8'd0,  2'd0, 8'h00, 12'sd0,    5'd0},  1'b1, V_NONE},
      '{'{OP_FEEDBACK, 40'hFF_FFFF_FFF8, 8'd1,   2'd2, 8'h00, 12'sd0,    5'd0},  1'b1, V_PITCH},
      '{'{OP_CHECK,    40'h00_0000_0010, 8'd0,   2'd0, 8'h00, 12'sd0,    5'd0},  1'b0, V_NONE},
      // heartbeat one past its limit across the wrap: first trip, then sticky
      '{'{OP_CHECK,    40'd99985,        8'd0,   2'd0, 8'h00, 12'sd0,    5'd0},  1'b1, V_FIRST},
      '{'{OP_CHECK,    40'd99985,        8'd0,   2'd0, 8'h00, 12'sd0,    5'd0},  1'b1, V_HBOLD},
      '{'{OP_SEND,     40'd99985,        8'd0,   2'd0, 8'h00, 12'sd0,    5'd0},  1'b1, V_LSEND},
      '{'{OP_SEND,     40'd99985,        8'd0,   2'd0, 8'h00, 12'sd0,    5'd4},  1'b1, V_LSEND},
      '{'{OP_SEND,     40'd99985,        8'd0,   2'd0, 8'h00, 12'sd0,    5'd16}, 1'b1, V_LATCH},
      '{'{OP_HEARTBEAT, 40'd99985,       8'd0,   2'd0, 8'h00, 12'sd0,    5'd0},  1'b1, V_LATCH},
      '{'{OP_FEEDBACK, 40'd99985,        8'd1,   2'd2, 8'h01, 12'sd0,    5'd0},  1'b1, V_LPIT},
      '{'{OP_CHECK,    40'd99985,        8'd0,   2'd0, 8'h00, 12'sd0,    5'd0},  1'b1, V_PBAD},
      // one tenth of a degree over the limit
      '{'{OP_FEEDBACK, 40'd99985,        8'd2,   2'd2, 8'h00, 12'sd751,  5'd0},  1'b1, V_LYAW},
      '{'{OP_CHECK,    40'd99985,        8'd0,   2'd0, 8'h00, 12'sd0,    5'd0},  1'b1, V_BOTH}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  csr_write_enable;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [CSR_BITS-1:0]   csr_write_data;
   logic                  req_valid;
   logic                  req_stall;
   logic [1:0]            req_operation;
   logic [TIME_BITS-1:0]  req_time_us;
   logic [7:0]            req_motor_id;
   logic [1:0]            req_fb_mode;
   logic [7:0]            req_fb_faults;
   logic signed [TEMP_BITS-1:0] req_fb_temp;
   logic [4:0]            req_comm_type;
   logic                  rsp_valid;
   logic                  rsp_stall;
   logic                  rsp_send_allowed;
   logic                  rsp_inhibited;
   logic                  rsp_trip_onset;
   logic                  rsp_issue_stops;
   logic                  rsp_heartbeat_stale;
   logic                  rsp_pitch_bad;
   logic                  rsp_yaw_bad;
   logic [1:0]            rsp_axis_matched;

   // register copies
   logic [7:0]         pitch_id   = PITCH_MOTOR_RST;
   logic [7:0]         yaw_id     = YAW_MOTOR_RST;
   logic [23:0]        hb_limit   = HB_LIMIT_RST;
   logic [23:0]        fb_limit   = FB_LIMIT_RST;
   logic signed [11:0] heat_limit = TEMP_LIMIT_RST;

   // interlock state copies (index 0 pitch, 1 yaw)
   logic [39:0]        hb_stamp = '0;
   logic               latched  = 1'b0;
   logic               axis_valid [2] = '{1'b0, 1'b0};
   logic [39:0]        axis_stamp [2] = '{40'd0, 40'd0};
   logic [1:0]         axis_run   [2] = '{2'd0, 2'd0};
   logic [7:0]         axis_fault [2] = '{8'd0, 8'd0};
   logic signed [11:0] axis_heat  [2] = '{12'sd0, 12'sd0};

   gate_verdict_type verdict_q [$];
   logic [39:0]   now_us      = 40'd300000;
   int            mismatches  = 0;
   int            gap_pct     = 6;
   int            stall_pct   = 69;
   int            hold_asked  = 0;

   motor_safety_watchdog_gate_core uut (.*);

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- model
   function automatic logic axis_unsafe(int a, logic [39:0] now);
      logic [39:0] age;
      age = now - axis_stamp[a];
      if (!axis_valid[a] || axis_run[a] != ACTIVE_MODE) return 1'b0;
      return (age > {16'd0, fb_limit}) || (axis_fault[a] != 8'd0) ||
             (axis_heat[a] > heat_limit);
   endfunction

   // apply one request to the state copy and return its response
   function automatic gate_verdict_type judge_request(gate_req_type rq);
      gate_verdict_type v;
      logic [39:0]   hb_age;
      int            a;
      v = '0;
      a = -1;
      case (rq.op)
         OP_HEARTBEAT: hb_stamp = rq.stamp;
         OP_FEEDBACK: begin
            // pitch wins when both ids are equal
            if (rq.motor == pitch_id) a = 0;
            else if (rq.motor == yaw_id) a = 1;
            if (a >= 0) begin
               axis_valid[a] = 1'b1;
               axis_stamp[a] = rq.stamp;
               axis_run[a]   = rq.mode;
               axis_fault[a] = rq.faults;
               axis_heat[a]  = $signed(rq.temp);
               v.axis_matched = (a == 0) ? MATCH_PITCH : MATCH_YAW;
            end
         end
         OP_CHECK: begin
            hb_age = rq.stamp - hb_stamp;
            v.heartbeat_stale = hb_age > {16'd0, hb_limit};
            v.pitch_bad = axis_unsafe(0, rq.stamp);
            v.yaw_bad   = axis_unsafe(1, rq.stamp);
            if (v.heartbeat_stale || v.pitch_bad || v.yaw_bad) begin
               v.trip_onset = !latched;
               latched = 1'b1;
            end
            v.issue_stops = latched;
         end
         default: begin
            v.send_allowed = !latched || rq.ctype == STOP_TYPE ||
                             rq.ctype == DISCOVER_TYPE || rq.ctype == READ_TYPE;
         end
      endcase
      v.inhibited = latched;
      return v;
   endfunction

   // --------------------------------------------------------- random requests
   function automatic gate_req_type make_random();
      gate_req_type rq;
      int        pick;
      int        heat;
      int        a;
      // time mostly creeps forward, sometimes leaps anywhere
      pick = $urandom_range(0, 99);
      if (pick < 50) now_us = now_us + 40'($urandom_range(0, 64));
      else if (pick < 85) now_us = now_us + 40'($urandom_range(0, 150000));
      else if (pick < 97) now_us = now_us + 40'($urandom_range(0, 32'hFF_FFFF));
      else now_us = {8'($urandom), $urandom};
      rq.stamp = now_us;

      pick = $urandom_range(0, 99);
      if (pick < 20) rq.op = OP_HEARTBEAT;
      else if (pick < 55) rq.op = OP_FEEDBACK;
      else if (pick < 80) rq.op = OP_CHECK;
      else rq.op = OP_SEND;

      pick = $urandom_range(0, 99);
      rq.motor  = pick < 45 ? pitch_id : pick < 85 ? yaw_id : 8'($urandom);
      rq.mode   = $urandom_range(0, 1) ? ACTIVE_MODE : 2'($urandom);
      rq.faults = $urandom_range(0, 99) < 70 ? 8'd0 : 8'($urandom);

      if ($urandom_range(0, 99) < 30) begin
         heat = int'(heat_limit) + int'($urandom_range(0, 2)) - 1;
         if (heat > 2000) heat = 2000;
         if (heat < -400) heat = -400;
      end else begin
         heat = int'($urandom_range(0, 2400)) - 400;
      end
      rq.temp = 12'(heat);

      pick = $urandom_range(0, 99);
      rq.ctype = pick < 13 ? DISCOVER_TYPE : pick < 26 ? STOP_TYPE :
                 pick < 40 ? READ_TYPE : 5'($urandom);

      // land some checks right on a limit or one past it
      if (rq.op == OP_CHECK && $urandom_range(0, 99) < 20) begin
         a = $urandom_range(0, 2);
         if (a == 2)
            rq.stamp = hb_stamp + {16'd0, hb_limit} + 40'($urandom_range(0, 1));
         else
            rq.stamp = axis_stamp[a] + {16'd0, fb_limit} + 40'($urandom_range(0, 1));
      end
      return rq;
   endfunction

   // ------------------------------------------------------------- request side
   task automatic offer(gate_req_type rq, logic typed, gate_verdict_type want);
      gate_verdict_type v;
      @(negedge clock);
      req_valid     = 1'b1;
      req_operation = rq.op;
      req_time_us   = rq.stamp;
      req_motor_id  = rq.motor;
      req_fb_mode   = rq.mode;
      req_fb_faults = rq.faults;
      req_fb_temp   = $signed(rq.temp);
      req_comm_type = rq.ctype;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      v = judge_request(rq);
      verdict_q.push_back(typed ? want : v);
   endtask

   // drop valid and scramble the opcode, stamp and motor id while idle
   task automatic pause_req(int cycles);
      @(negedge clock);
      req_valid     = 1'b0;
      req_operation = 2'($urandom);
      req_time_us   = {8'($urandom), $urandom};
      req_motor_id  = 8'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic drain();
      pause_req(1);
      while (verdict_q.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   task automatic program_reg(logic [CSR_IDX_BITS-1:0] idx, logic [23:0] data);
      @(negedge clock);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      case (idx)
         CSR_PITCH_MOTOR: pitch_id   = data[7:0];
         CSR_YAW_MOTOR:   yaw_id     = data[7:0];
         CSR_HB_LIMIT:    hb_limit   = data;
         CSR_FB_LIMIT:    fb_limit   = data;
         CSR_TEMP_LIMIT:  heat_limit = $signed(data[11:0]);
         default: ;
      endcase
   endtask

   task automatic run_phase(int count);
      for (int n = 0; n < count; n++) begin
         // before each request, idle while a random draw falls under gap_pct percent
         while ($urandom_range(0, 99) < gap_pct) pause_req(1);
         offer(make_random(), 1'b0, V_NONE);
      end
   endtask

   // ------------------------------------------------------------ response side
   // random stalls, plus a long hold-off whenever one is asked for
   initial begin
      int hold_left;
      int hold_served;
      hold_left   = 0;
      hold_served = 0;
      rsp_stall   = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_asked != hold_served) begin
            hold_served = hold_asked;
            hold_left   = 150;
         end
         if (hold_left > 0) begin
            rsp_stall = 1'b1;
            hold_left--;
         end else begin
            rsp_stall = $urandom_range(0, 99) < stall_pct;
         end
      end
   end

   task automatic check_field(string field, logic [1:0] want, logic [1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
         mismatches++;
      end
   endtask

   // compare each accepted response with the oldest expectation
   always @(posedge clock) begin
      gate_verdict_type want;
      if (!reset && rsp_valid === 1'b1 && !rsp_stall) begin
         if (verdict_q.size() == 0) begin
            $display("%0t: response with no request outstanding", $time);
            mismatches++;
         end else begin
            want = verdict_q.pop_front();
            check_field("send_allowed", 2'(want.send_allowed), 2'(rsp_send_allowed));
            check_field("inhibited", 2'(want.inhibited), 2'(rsp_inhibited));
            check_field("trip_onset", 2'(want.trip_onset), 2'(rsp_trip_onset));
            check_field("issue_stops", 2'(want.issue_stops), 2'(rsp_issue_stops));
            check_field("heartbeat_stale", 2'(want.heartbeat_stale),
                        2'(rsp_heartbeat_stale));
            check_field("pitch_bad", 2'(want.pitch_bad), 2'(rsp_pitch_bad));
            check_field("yaw_bad", 2'(want.yaw_bad), 2'(rsp_yaw_bad));
            check_field("axis_matched", want.axis_matched, rsp_axis_matched);
         end
      end
   end

   // --------------------------------------------------------------- sequence
   initial begin
      csr_write_enable = 1'b0;
      csr_index        = '0;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_operation    = OP_HEARTBEAT;
      req_time_us      = '0;
      req_motor_id     = '0;
      req_fb_mode      = '0;
      req_fb_faults    = '0;
      req_fb_temp      = '0;
      req_comm_type    = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // writes past the last register must leave the defaults alone
      for (int i = CSR_TEMP_LIMIT + 1; i < (1 << CSR_IDX_BITS); i++)
         program_reg(CSR_IDX_BITS'(i), 24'hFF_FFFF);

      foreach (script[i]) begin
         while ($urandom_range(0, 99) < gap_pct) pause_req(1);
         offer(script[i].rq, script[i].typed, script[i].want);
      end
      drain();

      // lowest and highest ids, widest heartbeat window, zero feedback window, coldest limit
      program_reg(CSR_PITCH_MOTOR, 24'd0);
      program_reg(CSR_YAW_MOTOR, 24'd255);
      program_reg(CSR_HB_LIMIT, 24'hFF_FFFF);
      program_reg(CSR_FB_LIMIT, 24'd0);
      program_reg(CSR_TEMP_LIMIT, {12'd0, 12'(-400)});
      run_phase(480);
      drain();

      // both axes on one id, smallest nonzero heartbeat window, hottest limit
      gap_pct   = 69;
      stall_pct = 6;
      program_reg(CSR_PITCH_MOTOR, 24'd7);
      program_reg(CSR_YAW_MOTOR, 24'd7);
      program_reg(CSR_HB_LIMIT, 24'd1);
      program_reg(CSR_FB_LIMIT, 24'hFF_FFFF);
      program_reg(CSR_TEMP_LIMIT, {12'd0, 12'(2000)});
      run_phase(480);
      drain();

      // random settings, full rate; opens with a long response hold-off
      gap_pct   = 0;
      stall_pct = 0;
      program_reg(CSR_PITCH_MOTOR, 24'($urandom_range(0, 255)));
      program_reg(CSR_YAW_MOTOR, 24'($urandom_range(0, 255)));
      program_reg(CSR_HB_LIMIT, 24'($urandom_range(1, 300000)));
      program_reg(CSR_FB_LIMIT, 24'($urandom_range(1, 300000)));
      program_reg(CSR_TEMP_LIMIT, {12'd0, 12'(int'($urandom_range(0, 2400)) - 400)});
      @(posedge clock);
      hold_asked++;
      run_phase(240);
      drain();
      run_phase(240);
      drain();

      if (mismatches == 0 && verdict_q.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog on the bench itself
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/msw_pkg.sv
hw/rtl/msw_axis.sv
hw/rtl/motor_safety_watchdog_gate_core.sv
bench/tb_top.sv
